// ===== hw/rtl/okvt_pkg.sv =====
// ----------------------------------------------------------------------------
// okvt_pkg
// Types and constants shared by the ordered key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package okvt_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [2:0] {
    ACT_LOOKUP_KEY   = 3'd0,
    ACT_SET          = 3'd1,
    ACT_ERASE        = 3'd2,
    ACT_LOOKUP_VALUE = 3'd3,
    ACT_READ_INDEX   = 3'd4,
    ACT_CLEAR        = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_INDEX,
    ST_INDEX_DATA,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] key_in;
    logic [31:0] value_in;
    logic [3:0]  position_in;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        found;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic [3:0]  position_out;
    logic [4:0]  entry_total;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/okvt_ram.sv =====
// ----------------------------------------------------------------------------
// okvt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module okvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/okvt_seq.sv =====
// ----------------------------------------------------------------------------
// okvt_seq
// Request sequencer: scans, updates and compacts the key and value memories.
// ----------------------------------------------------------------------------
`default_nettype none

module okvt_seq #(
  parameter int DEPTH = okvt_pkg::DEPTH_DEF,
  parameter int KW    = okvt_pkg::KEY_BITS_DEF,
  parameter int VW    = okvt_pkg::VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire okvt_pkg::in_item_t in_data,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output okvt_pkg::out_item_t     res_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > 4) ? CW : 4;

  okvt_pkg::seq_state_t state_r, state_nxt;
  okvt_pkg::action_t    act_r, act_nxt;
  logic [KW-1:0]        key_r, key_nxt;
  logic [VW-1:0]        val_r, val_nxt;
  logic [3:0]           pos_r, pos_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [PW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 pend_r, pend_nxt;

  okvt_pkg::status_t    rs_status_r, rs_status_nxt;
  logic                 rs_found_r, rs_found_nxt;
  logic [31:0]          rs_key_r, rs_key_nxt;
  logic [31:0]          rs_val_r, rs_val_nxt;
  logic [3:0]           rs_pos_r, rs_pos_nxt;

  logic          mem_we_k, mem_we_v;
  logic [PW-1:0] mem_waddr, mem_raddr;
  logic [KW-1:0] wdata_k, rdata_k;
  logic [VW-1:0] wdata_v, rdata_v;

  logic          hit, scan_end, more, in_rng;
  logic [CW-1:0] nxt_idx;

  okvt_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (mem_we_k),
    .waddr (mem_waddr),
    .wdata (wdata_k),
    .raddr (mem_raddr),
    .rdata (rdata_k)
  );

  okvt_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (mem_we_v),
    .waddr (mem_waddr),
    .wdata (wdata_v),
    .raddr (mem_raddr),
    .rdata (rdata_v)
  );

  assign hit      = pend_r && ((act_r == okvt_pkg::ACT_LOOKUP_VALUE) ?
                               (rdata_v == val_r) : (rdata_k == key_r));
  assign scan_end = (rd_idx_r >= cnt_r);
  assign nxt_idx  = CW'(cmp_idx_r) + CW'(1);
  assign more     = (nxt_idx < cnt_r);
  assign in_rng   = (IW'(pos_r) < IW'(cnt_r));

  assign in_stall  = (state_r != okvt_pkg::ST_IDLE);
  assign res_valid = (state_r == okvt_pkg::ST_DONE);

  always_comb begin
    res_data              = '0;
    res_data.status       = rs_status_r;
    res_data.found        = rs_found_r;
    res_data.key_out      = rs_key_r;
    res_data.value_out    = rs_val_r;
    res_data.position_out = rs_pos_r;
    res_data.entry_total  = 5'(cnt_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      okvt_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.action)
            okvt_pkg::ACT_LOOKUP_KEY,
            okvt_pkg::ACT_SET,
            okvt_pkg::ACT_ERASE,
            okvt_pkg::ACT_LOOKUP_VALUE: state_nxt = okvt_pkg::ST_SCAN;
            okvt_pkg::ACT_READ_INDEX:   state_nxt = okvt_pkg::ST_INDEX;
            default:                    state_nxt = okvt_pkg::ST_DONE;
          endcase
        end
      end
      okvt_pkg::ST_SCAN: begin
        if (hit) begin
          state_nxt = (act_r == okvt_pkg::ACT_ERASE && more) ?
                      okvt_pkg::ST_SHIFT : okvt_pkg::ST_DONE;
        end else if (scan_end) begin
          state_nxt = okvt_pkg::ST_DONE;
        end
      end
      okvt_pkg::ST_SHIFT: begin
        if (scan_end) begin
          state_nxt = okvt_pkg::ST_DONE;
        end
      end
      okvt_pkg::ST_INDEX: begin
        state_nxt = in_rng ? okvt_pkg::ST_INDEX_DATA : okvt_pkg::ST_DONE;
      end
      okvt_pkg::ST_INDEX_DATA: begin
        state_nxt = okvt_pkg::ST_DONE;
      end
      okvt_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = okvt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = okvt_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    act_nxt       = act_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    pend_nxt      = pend_r;
    rs_status_nxt = rs_status_r;
    rs_found_nxt  = rs_found_r;
    rs_key_nxt    = rs_key_r;
    rs_val_nxt    = rs_val_r;
    rs_pos_nxt    = rs_pos_r;
    mem_we_k      = 1'b0;
    mem_we_v      = 1'b0;
    mem_waddr     = cmp_idx_r;
    mem_raddr     = rd_idx_r[PW-1:0];
    wdata_k       = key_r;
    wdata_v       = val_r;

    unique case (state_r)
      okvt_pkg::ST_IDLE: begin
        if (in_valid) begin
          act_nxt       = in_data.action;
          key_nxt       = in_data.key_in[KW-1:0];
          val_nxt       = in_data.value_in[VW-1:0];
          pos_nxt       = in_data.position_in;
          rd_idx_nxt    = '0;
          pend_nxt      = 1'b0;
          rs_status_nxt = okvt_pkg::STAT_OK;
          rs_found_nxt  = 1'b0;
          rs_key_nxt    = '0;
          rs_val_nxt    = '0;
          rs_pos_nxt    = '0;
          if (in_data.action == okvt_pkg::ACT_CLEAR) begin
            cnt_nxt = '0;
          end
        end
      end
      okvt_pkg::ST_SCAN: begin
        if (hit) begin
          pend_nxt      = 1'b0;
          rs_status_nxt = okvt_pkg::STAT_OK;
          rs_found_nxt  = 1'b1;
          rs_pos_nxt    = 4'(cmp_idx_r);
          unique case (act_r)
            okvt_pkg::ACT_SET: begin
              mem_we_v   = 1'b1;
              rs_key_nxt = 32'(key_r);
              rs_val_nxt = 32'(val_r);
            end
            okvt_pkg::ACT_ERASE: begin
              rs_key_nxt = 32'(rdata_k);
              rs_val_nxt = 32'(rdata_v);
              if (more) begin
                rd_idx_nxt = nxt_idx;
              end else begin
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            default: begin
              rs_key_nxt = 32'(rdata_k);
              rs_val_nxt = 32'(rdata_v);
            end
          endcase
        end else if (scan_end) begin
          pend_nxt = 1'b0;
          if (act_r == okvt_pkg::ACT_SET) begin
            if (cnt_r < CW'(DEPTH)) begin
              mem_we_k      = 1'b1;
              mem_we_v      = 1'b1;
              mem_waddr     = cnt_r[PW-1:0];
              cnt_nxt       = cnt_r + CW'(1);
              rs_status_nxt = okvt_pkg::STAT_OK;
              rs_key_nxt    = 32'(key_r);
              rs_val_nxt    = 32'(val_r);
              rs_pos_nxt    = 4'(cnt_r);
            end else begin
              rs_status_nxt = okvt_pkg::STAT_FULL;
            end
          end else begin
            rs_status_nxt = okvt_pkg::STAT_NOT_FOUND;
          end
        end else begin
          pend_nxt    = 1'b1;
          cmp_idx_nxt = rd_idx_r[PW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
      end
      okvt_pkg::ST_SHIFT: begin
        if (pend_r) begin
          mem_we_k  = 1'b1;
          mem_we_v  = 1'b1;
          mem_waddr = cmp_idx_r - PW'(1);
          wdata_k   = rdata_k;
          wdata_v   = rdata_v;
        end
        if (scan_end) begin
          pend_nxt = 1'b0;
          cnt_nxt  = cnt_r - CW'(1);
        end else begin
          pend_nxt    = 1'b1;
          cmp_idx_nxt = rd_idx_r[PW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
      end
      okvt_pkg::ST_INDEX: begin
        mem_raddr = PW'(pos_r);
        if (!in_rng) begin
          rs_status_nxt = okvt_pkg::STAT_RANGE;
        end
      end
      okvt_pkg::ST_INDEX_DATA: begin
        rs_status_nxt = okvt_pkg::STAT_OK;
        rs_found_nxt  = 1'b1;
        rs_key_nxt    = 32'(rdata_k);
        rs_val_nxt    = 32'(rdata_v);
        rs_pos_nxt    = pos_r;
      end
      okvt_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= okvt_pkg::ST_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    pos_r       <= pos_nxt;
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    rs_status_r <= rs_status_nxt;
    rs_found_r  <= rs_found_nxt;
    rs_key_r    <= rs_key_nxt;
    rs_val_r    <= rs_val_nxt;
    rs_pos_r    <= rs_pos_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_key_value_table_core.sv =====
// ----------------------------------------------------------------------------
// ordered_key_value_table_core
// Ordered key/value table with linear search over on-chip memories.
// ----------------------------------------------------------------------------
// Holds up to DEPTH key/value pairs in insertion order in two RAMs that share
// one read address and one write address, and takes one request at a time.
// Searches (lookup, set, erase, reverse lookup) read one entry per cycle from
// position 0 until a match or the last entry present. Erase then moves every
// later pair down one place at one entry per cycle. Read by index reads the
// entry at the given position and reports a range status when the position
// is out of range; clear and unused actions go straight to the result. A
// finished result waits in the output register, so the next request is taken
// while it is still stalled.
`default_nettype none

module ordered_key_value_table_core #(
  parameter int DEPTH      = okvt_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire okvt_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output okvt_pkg::out_item_t      out_data
);

  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  logic                res_valid, res_ready;
  okvt_pkg::out_item_t res_data;
  logic                out_valid_r;
  okvt_pkg::out_item_t out_data_r;

  okvt_seq #(.DEPTH(DEPTH), .KW(KW), .VW(VW)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
